[src/bf3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants of the 3x3 RGB box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

   localparam int MaxSide = 1024;
   localparam int ColW    = $clog2(MaxSide);
   localparam int SideW   = 11;
   localparam int PixW    = 16;
   localparam int RowSumW = PixW + 2;
   localparam int SumW    = PixW + 4;

   localparam logic [SideW-1:0] SideReset = 11'd512;
   localparam logic [SideW-1:0] SideMin   = 11'd2;
   localparam logic [SideW-1:0] SideMax   = SideW'(MaxSide);

   // mean = (sum * Recip) >> RecipShift, exact for all sums of up to nine pixels
   localparam int RecipShift = SumW + 4;
   localparam int RecipW     = RecipShift - 1;
   localparam int ProdW      = SumW + RecipW;
   localparam logic [RecipW-1:0] Recip4 = RecipW'((64'd1 << RecipShift) / 4);
   localparam logic [RecipW-1:0] Recip6 = RecipW'(((64'd1 << RecipShift) + 5) / 6);
   localparam logic [RecipW-1:0] Recip9 = RecipW'(((64'd1 << RecipShift) + 8) / 9);

   typedef struct packed {
      logic [PixW-1:0] red;
      logic [PixW-1:0] green;
      logic [PixW-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } row_pair_type;

   typedef struct packed {
      logic [RowSumW-1:0] red;
      logic [RowSumW-1:0] green;
      logic [RowSumW-1:0] blue;
   } row_sum_type;

   // border flags of the output pixel being formed
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic frame_end;
   } pos_type;

endpackage

[src/bf3_line_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_line_buf
// Two-row line store; one entry per column holds the pixels one and two rows
// back. Registered read, write shifts the newer pixel into the older slot.
// ----------------------------------------------------------------------------
module bf3_line_buf (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [bf3_pkg::ColW-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [bf3_pkg::ColW-1:0] wr_addr,
   input  bf3_pkg::pixel_type       wr_pix,
   output bf3_pkg::pixel_type       older_pix,
   output bf3_pkg::pixel_type       newer_pix
);

   bf3_pkg::row_pair_type mem_ff [bf3_pkg::MaxSide];
   bf3_pkg::row_pair_type rd_ff;
   bf3_pkg::row_pair_type wr_in;

   always_comb begin
      wr_in.older = rd_ff.newer;
      wr_in.newer = wr_pix;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_in;
      end
   end

   assign older_pix = rd_ff.older;
   assign newer_pix = rd_ff.newer;

endmodule

[src/bf3_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_window
// 3x3 window registers and the column-clipped per-row sums.
// ----------------------------------------------------------------------------
module bf3_window (
   input  logic                  clock,
   input  logic                  shift_en,
   input  bf3_pkg::pixel_type    older_pix,
   input  bf3_pkg::pixel_type    newer_pix,
   input  bf3_pkg::pixel_type    cur_pix,
   input  logic                  sum_en,
   input  bf3_pkg::pos_type      pos,
   output bf3_pkg::row_sum_type  row_sum [3],
   output bf3_pkg::pos_type      pos_out
);

   bf3_pkg::pixel_type   win_ff [3][3];
   bf3_pkg::row_sum_type row_sum_ff [3];
   bf3_pkg::row_sum_type row_sum_in [3];
   bf3_pkg::pos_type     pos_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= older_pix;
         win_ff[1][2] <= newer_pix;
         win_ff[2][2] <= cur_pix;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum_in[r].red   = bf3_pkg::RowSumW'(win_ff[r][1].red)
            + (pos.left  ? '0 : bf3_pkg::RowSumW'(win_ff[r][0].red))
            + (pos.right ? '0 : bf3_pkg::RowSumW'(win_ff[r][2].red));
         row_sum_in[r].green = bf3_pkg::RowSumW'(win_ff[r][1].green)
            + (pos.left  ? '0 : bf3_pkg::RowSumW'(win_ff[r][0].green))
            + (pos.right ? '0 : bf3_pkg::RowSumW'(win_ff[r][2].green));
         row_sum_in[r].blue  = bf3_pkg::RowSumW'(win_ff[r][1].blue)
            + (pos.left  ? '0 : bf3_pkg::RowSumW'(win_ff[r][0].blue))
            + (pos.right ? '0 : bf3_pkg::RowSumW'(win_ff[r][2].blue));
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         row_sum_ff <= row_sum_in;
         pos_ff     <= pos;
      end
   end

   assign row_sum = row_sum_ff;
   assign pos_out = pos_ff;

endmodule

[src/bf3_mean.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_mean
// Row-clipped window sum, then division by the pixel count (4, 6 or 9) as a
// multiply by a reciprocal. The product register is the result register.
// ----------------------------------------------------------------------------
module bf3_mean (
   input  logic                  clock,
   input  logic                  sum_en,
   input  bf3_pkg::row_sum_type  row_sum [3],
   input  bf3_pkg::pos_type      pos,
   input  logic                  mul_en,
   output logic [bf3_pkg::PixW-1:0] out_red,
   output logic [bf3_pkg::PixW-1:0] out_green,
   output logic [bf3_pkg::PixW-1:0] out_blue,
   output logic                  frame_end
);

   localparam int Lo = bf3_pkg::RecipShift;
   localparam int Hi = bf3_pkg::RecipShift + bf3_pkg::PixW - 1;

   logic [bf3_pkg::SumW-1:0]   sum_red_in, sum_green_in, sum_blue_in;
   logic [bf3_pkg::SumW-1:0]   sum_red_ff, sum_green_ff, sum_blue_ff;
   logic [bf3_pkg::RecipW-1:0] recip_in, recip_ff;
   logic                       fend_ff;
   logic [bf3_pkg::ProdW-1:0]  prod_red_ff, prod_green_ff, prod_blue_ff;
   logic                       fend_out_ff;
   logic                       row_clip, col_clip;

   always_comb begin
      sum_red_in   = bf3_pkg::SumW'(row_sum[1].red)
         + (pos.top    ? '0 : bf3_pkg::SumW'(row_sum[0].red))
         + (pos.bottom ? '0 : bf3_pkg::SumW'(row_sum[2].red));
      sum_green_in = bf3_pkg::SumW'(row_sum[1].green)
         + (pos.top    ? '0 : bf3_pkg::SumW'(row_sum[0].green))
         + (pos.bottom ? '0 : bf3_pkg::SumW'(row_sum[2].green));
      sum_blue_in  = bf3_pkg::SumW'(row_sum[1].blue)
         + (pos.top    ? '0 : bf3_pkg::SumW'(row_sum[0].blue))
         + (pos.bottom ? '0 : bf3_pkg::SumW'(row_sum[2].blue));
      row_clip = pos.top || pos.bottom;
      col_clip = pos.left || pos.right;
      if (row_clip && col_clip) begin
         recip_in = bf3_pkg::Recip4;
      end else if (row_clip || col_clip) begin
         recip_in = bf3_pkg::Recip6;
      end else begin
         recip_in = bf3_pkg::Recip9;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_red_ff   <= sum_red_in;
         sum_green_ff <= sum_green_in;
         sum_blue_ff  <= sum_blue_in;
         recip_ff     <= recip_in;
         fend_ff      <= pos.frame_end;
      end
      if (mul_en) begin
         prod_red_ff   <= bf3_pkg::ProdW'(sum_red_ff)   * bf3_pkg::ProdW'(recip_ff);
         prod_green_ff <= bf3_pkg::ProdW'(sum_green_ff) * bf3_pkg::ProdW'(recip_ff);
         prod_blue_ff  <= bf3_pkg::ProdW'(sum_blue_ff)  * bf3_pkg::ProdW'(recip_ff);
         fend_out_ff   <= fend_ff;
      end
   end

   assign out_red   = prod_red_ff[Hi:Lo];
   assign out_green = prod_green_ff[Hi:Lo];
   assign out_blue  = prod_blue_ff[Hi:Lo];
   assign frame_end = fend_out_ff;

endmodule

[src/box_filter_3x3_rgb_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb_core
// Streaming 3x3 mean filter over a square RGB image with border clipping.
//
//   Port group   Direction  Handshake            Contents
//   req_*        in         req_valid/req_stall  mode, pixel channels
//   rsp_*        out        rsp_valid/rsp_stall  mean channels, frame_end
//   csr_*        in         csr_wr_en            side_length
//
// One item per cycle while rsp_stall does not hold the pipeline. Five register
// stages: input/line-store read, window, row sums, window sum, reciprocal
// multiply (result register).
// Each stage holds while the next one is full and stalled; bubbles close up.
// Reset clears the position counters and sets side_length to 512.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [bf3_pkg::PixW-1:0]      req_in_red,
   input  logic [bf3_pkg::PixW-1:0]      req_in_green,
   input  logic [bf3_pkg::PixW-1:0]      req_in_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bf3_pkg::PixW-1:0]      rsp_out_red,
   output logic [bf3_pkg::PixW-1:0]      rsp_out_green,
   output logic [bf3_pkg::PixW-1:0]      rsp_out_blue,
   output logic                          rsp_frame_end,
   input  logic                          csr_wr_en,
   input  logic [bf3_pkg::SideW-1:0]     csr_wr_data
);

   logic [bf3_pkg::SideW-1:0] side_ff;
   logic [bf3_pkg::SideW-1:0] n_eff, n_last;
   logic [bf3_pkg::SideW-1:0] in_row_ff, in_row_in;
   logic [bf3_pkg::ColW-1:0]  in_col_ff, in_col_in;
   logic [bf3_pkg::ColW-1:0]  out_row_ff, out_row_in;
   logic [bf3_pkg::ColW-1:0]  out_col_ff, out_col_in;

   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;
   logic accept, pixels_done, proc, emit;

   bf3_pkg::pixel_type       pix_in, pix0_ff;
   logic [bf3_pkg::ColW-1:0] col0_ff;
   logic                     emit0_ff;
   bf3_pkg::pos_type         pos_in, pos0_ff, pos2;
   bf3_pkg::pixel_type       older_pix, newer_pix;
   bf3_pkg::row_sum_type     row_sum [3];

   // pipeline flow
   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign rdy0      = !v0_ff || rdy1;
   assign req_stall = !rdy0;
   assign accept    = req_valid && rdy0;
   assign rsp_valid = v4_ff;

   always_comb begin
      if (side_ff < bf3_pkg::SideMin) begin
         n_eff = bf3_pkg::SideMin;
      end else if (side_ff > bf3_pkg::SideMax) begin
         n_eff = bf3_pkg::SideMax;
      end else begin
         n_eff = side_ff;
      end
      n_last      = n_eff - 1'b1;
      pixels_done = in_row_ff >= n_eff;
      proc        = accept && (pixels_done || !req_mode);
      emit        = (in_row_ff >= bf3_pkg::SideW'(2))
                 || (in_row_ff == bf3_pkg::SideW'(1) && in_col_ff != '0);

      pos_in.top       = out_row_ff == '0;
      pos_in.bottom    = {1'b0, out_row_ff} == n_last;
      pos_in.left      = out_col_ff == '0;
      pos_in.right     = {1'b0, out_col_ff} == n_last;
      pos_in.frame_end = pos_in.bottom && pos_in.right;

      pix_in.red   = pixels_done ? '0 : req_in_red;
      pix_in.green = pixels_done ? '0 : req_in_green;
      pix_in.blue  = pixels_done ? '0 : req_in_blue;

      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (proc) begin
         if (emit && pos_in.frame_end) begin
            in_row_in  = '0;
            in_col_in  = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else begin
            if (emit) begin
               if (pos_in.right) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
            if ({1'b0, in_col_ff} == n_last) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 1'b1;
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff    <= bf3_pkg::SideReset;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else if (csr_wr_en) begin
         side_ff    <= csr_wr_data;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= proc;
         if (rdy1) v1_ff <= v0_ff && emit0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         pix0_ff  <= pix_in;
         col0_ff  <= in_col_ff;
         emit0_ff <= emit;
         pos0_ff  <= pos_in;
      end
   end

   bf3_line_buf u_line_buf (
      .clock     (clock),
      .rd_en     (proc),
      .rd_addr   (in_col_ff),
      .wr_en     (v0_ff && rdy1),
      .wr_addr   (col0_ff),
      .wr_pix    (pix0_ff),
      .older_pix (older_pix),
      .newer_pix (newer_pix)
   );

   // window stage holds pos0 of the item that completed it
   bf3_pkg::pos_type pos1_ff;

   always_ff @(posedge clock) begin
      if (v0_ff && rdy1) begin
         pos1_ff <= pos0_ff;
      end
   end

   bf3_window u_window (
      .clock     (clock),
      .shift_en  (v0_ff && rdy1),
      .older_pix (older_pix),
      .newer_pix (newer_pix),
      .cur_pix   (pix0_ff),
      .sum_en    (v1_ff && rdy2),
      .pos       (pos1_ff),
      .row_sum   (row_sum),
      .pos_out   (pos2)
   );

   bf3_mean u_mean (
      .clock     (clock),
      .sum_en    (v2_ff && rdy3),
      .row_sum   (row_sum),
      .pos       (pos2),
      .mul_en    (v3_ff && rdy4),
      .out_red   (rsp_out_red),
      .out_green (rsp_out_green),
      .out_blue  (rsp_out_blue),
      .frame_end (rsp_frame_end)
   );

endmodule
